// File: hw/rtl/ps2kbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2kbd_pkg
// Shared types, constants and scan code tables for the PS/2 Set 2 decoder
// with its key event ring.
// ----------------------------------------------------------------------------
package ps2kbd_pkg;

    // Ring of key events; one slot is kept free to tell full from empty.
    localparam int FIFO_DEPTH = 256;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    // Result queue behind the ring read stage.
    localparam int OQ_DEPTH = 3;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    localparam int KEY_W = 7;

    // Prefix bytes of Set 2.
    localparam logic [7:0] PREFIX_EXT = 8'hE0;
    localparam logic [7:0] PREFIX_BRK = 8'hF0;

    // Action codes.
    localparam logic ACT_SCAN = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    typedef enum logic [1:0] {
        PH_NORMAL    = 2'd0,
        PH_BREAK     = 2'd1,
        PH_EXT       = 2'd2,
        PH_EXT_BREAK = 2'd3
    } phase_t;

    typedef struct packed {
        logic       action;
        logic [7:0] scan_byte;
    } in_t;

    typedef struct packed {
        logic             event_valid;
        logic [KEY_W-1:0] key_id;
        logic             key_pressed;
        logic             queued;
        logic             dropped;
    } out_t;

    // One stored event: make flag over key code.
    typedef struct packed {
        logic             make;
        logic [KEY_W-1:0] key;
    } event_t;

    // Normal table: byte to key code, zero when unmapped.
    function automatic logic [KEY_W-1:0] normal_lookup(input logic [7:0] b);
        logic [KEY_W-1:0] k;
        case (b)
            8'h1C: k = 7'd1;   8'h32: k = 7'd2;   8'h21: k = 7'd3;   8'h23: k = 7'd4;
            8'h24: k = 7'd5;   8'h2B: k = 7'd6;   8'h34: k = 7'd7;   8'h33: k = 7'd8;
            8'h43: k = 7'd9;   8'h3B: k = 7'd10;  8'h42: k = 7'd11;  8'h4B: k = 7'd12;
            8'h3A: k = 7'd13;  8'h31: k = 7'd14;  8'h44: k = 7'd15;  8'h4D: k = 7'd16;
            8'h15: k = 7'd17;  8'h2D: k = 7'd18;  8'h1B: k = 7'd19;  8'h2C: k = 7'd20;
            8'h3C: k = 7'd21;  8'h2A: k = 7'd22;  8'h1D: k = 7'd23;  8'h22: k = 7'd24;
            8'h35: k = 7'd25;  8'h1A: k = 7'd26;  8'h0E: k = 7'd27;  8'h16: k = 7'd28;
            8'h1E: k = 7'd29;  8'h26: k = 7'd30;  8'h25: k = 7'd31;  8'h2E: k = 7'd32;
            8'h36: k = 7'd33;  8'h3D: k = 7'd34;  8'h3E: k = 7'd35;  8'h46: k = 7'd36;
            8'h45: k = 7'd37;  8'h4E: k = 7'd38;  8'h55: k = 7'd39;  8'h66: k = 7'd40;
            8'h54: k = 7'd41;  8'h5B: k = 7'd42;  8'h5D: k = 7'd43;  8'h4C: k = 7'd44;
            8'h52: k = 7'd45;  8'h41: k = 7'd46;  8'h49: k = 7'd47;  8'h4A: k = 7'd48;
            8'h5A: k = 7'd49;  8'h29: k = 7'd50;  8'h0D: k = 7'd51;  8'h76: k = 7'd52;
            8'h58: k = 7'd53;  8'h12: k = 7'd54;  8'h59: k = 7'd54;  8'h14: k = 7'd55;
            8'h11: k = 7'd56;  8'h05: k = 7'd57;  8'h06: k = 7'd58;  8'h04: k = 7'd59;
            8'h0C: k = 7'd60;  8'h03: k = 7'd61;  8'h0B: k = 7'd62;  8'h83: k = 7'd63;
            8'h0A: k = 7'd64;  8'h01: k = 7'd65;  8'h09: k = 7'd66;  8'h78: k = 7'd67;
            8'h07: k = 7'd68;
            default: k = '0;
        endcase
        return k;
    endfunction

    // Extended table, used after the E0 prefix.
    function automatic logic [KEY_W-1:0] extended_lookup(input logic [7:0] b);
        logic [KEY_W-1:0] k;
        case (b)
            8'h75: k = 7'd69;  8'h72: k = 7'd70;  8'h6B: k = 7'd71;  8'h74: k = 7'd72;
            8'h71: k = 7'd73;  8'h14: k = 7'd55;  8'h11: k = 7'd56;  8'h1F: k = 7'd74;
            8'h27: k = 7'd74;  8'h4A: k = 7'd48;  8'h5A: k = 7'd49;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

// File: hw/rtl/ps2_set2_scancode_decoder_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_set2_scancode_decoder_fifo
// Decodes PS/2 Set 2 scan bytes into make and break key events, keeps them
// in a ring held in a synchronous memory, and hands them out on pop requests.
// ----------------------------------------------------------------------------
//  Channel | Signals                            | Beat
//  --------+------------------------------------+------------------------------
//  in      | in_valid, in_ready, in_data (in_t) | one scan byte or one pop
//  out     | out_valid, out_ready, out_data     | one result per input beat
//
//  One input beat is accepted per cycle while in_ready is high. The decode
//  and the ring write or ring read happen in the accept cycle; the memory read
//  data and the result flags are registered in the read stage, and the result
//  then passes through the result queue to the output.
//  Reset clears the decode phase, the ring indexes and the result queue; the
//  event memory itself is not cleared, since only written slots are read.
//  While out_ready is low the three-entry result queue absorbs results; in_ready
//  drops once the queue and the read stage together hold three results.
// ----------------------------------------------------------------------------
module ps2_set2_scancode_decoder_fifo
    import ps2kbd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    phase_t              phase_reg, phase_next;
    logic [PTR_W-1:0]    wr_idx_reg, rd_idx_reg;
    logic [PTR_W-1:0]    wr_idx_inc, rd_idx_inc;
    logic                in_fire, scan_fire, pop_fire;
    logic                key_done;
    logic                key_make;
    logic [KEY_W-1:0]    lookup_key;
    logic                ring_full, ring_empty;
    logic                push_ok, push_drop, pop_hit;

    event_t              event_mem [FIFO_DEPTH];
    event_t              rd_data_reg;

    logic                s1_valid_reg;
    logic                s1_pop_hit_reg;
    logic                s1_queued_reg;
    logic                s1_dropped_reg;
    out_t                s1_result;

    out_t                oq_data_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] oq_head_reg, oq_tail_reg;
    logic [OQ_CNT_W-1:0] oq_count_reg;
    logic                oq_push, oq_pop;

    // Input handshake: space is reserved for every result in flight.
    assign in_ready  = ({1'b0, oq_count_reg} + {{OQ_CNT_W{1'b0}}, s1_valid_reg})
                       < (OQ_CNT_W + 1)'(OQ_DEPTH);
    assign in_fire   = in_valid && in_ready;
    assign scan_fire = in_fire && (in_data.action == ACT_SCAN);
    assign pop_fire  = in_fire && (in_data.action == ACT_POP);

    // Decode phase machine and table lookup.
    always_comb
    begin
        phase_next = phase_reg;
        key_done   = 1'b0;
        key_make   = 1'b0;
        lookup_key = '0;
        if (scan_fire)
        begin
            case (phase_reg)
                PH_NORMAL:
                begin
                    if (in_data.scan_byte == PREFIX_EXT)
                    begin
                        phase_next = PH_EXT;
                    end
                    else if (in_data.scan_byte == PREFIX_BRK)
                    begin
                        phase_next = PH_BREAK;
                    end
                    else
                    begin
                        key_done   = 1'b1;
                        key_make   = 1'b1;
                        lookup_key = normal_lookup(in_data.scan_byte);
                    end
                end
                PH_BREAK:
                begin
                    key_done   = 1'b1;
                    lookup_key = normal_lookup(in_data.scan_byte);
                    phase_next = PH_NORMAL;
                end
                PH_EXT:
                begin
                    if (in_data.scan_byte == PREFIX_BRK)
                    begin
                        phase_next = PH_EXT_BREAK;
                    end
                    else
                    begin
                        key_done   = 1'b1;
                        key_make   = 1'b1;
                        lookup_key = extended_lookup(in_data.scan_byte);
                        phase_next = PH_NORMAL;
                    end
                end
                default:
                begin
                    key_done   = 1'b1;
                    lookup_key = extended_lookup(in_data.scan_byte);
                    phase_next = PH_NORMAL;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NORMAL;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // Ring index arithmetic and occupancy.
    assign wr_idx_inc = (wr_idx_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;
    assign rd_idx_inc = (rd_idx_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_idx_reg + 1'b1;
    assign ring_full  = (wr_idx_inc == rd_idx_reg);
    assign ring_empty = (wr_idx_reg == rd_idx_reg);

    assign push_ok   = key_done && (lookup_key != '0) && !ring_full;
    assign push_drop = key_done && (lookup_key != '0) && ring_full;
    assign pop_hit   = pop_fire && !ring_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
        end
        else
        begin
            if (push_ok)
            begin
                wr_idx_reg <= wr_idx_inc;
            end
            if (pop_hit)
            begin
                rd_idx_reg <= rd_idx_inc;
            end
        end
    end

    // Event memory: one write port, one registered read port. A push and a
    // pop never share a cycle, and a write lands before any later read.
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            event_mem[wr_idx_reg] <= '{make: key_make, key: lookup_key};
        end
        if (pop_hit)
        begin
            rd_data_reg <= event_mem[rd_idx_reg];
        end
    end

    // Read stage: result flags are registered alongside the memory read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s1_pop_hit_reg <= 1'b0;
            s1_queued_reg  <= 1'b0;
            s1_dropped_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= in_fire;
            s1_pop_hit_reg <= pop_hit;
            s1_queued_reg  <= push_ok;
            s1_dropped_reg <= push_drop;
        end
    end

    always_comb
    begin
        s1_result.event_valid = s1_pop_hit_reg;
        s1_result.key_id      = s1_pop_hit_reg ? rd_data_reg.key : '0;
        s1_result.key_pressed = s1_pop_hit_reg && rd_data_reg.make;
        s1_result.queued      = s1_queued_reg;
        s1_result.dropped     = s1_dropped_reg;
    end

    // Result queue in front of the output port.
    assign oq_push   = s1_valid_reg;
    assign out_valid = (oq_count_reg != '0);
    assign oq_pop    = out_valid && out_ready;
    assign out_data  = oq_data_reg[oq_head_reg];

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_data_reg[oq_tail_reg] <= s1_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_head_reg  <= '0;
            oq_tail_reg  <= '0;
            oq_count_reg <= '0;
        end
        else
        begin
            if (oq_push)
            begin
                oq_tail_reg <= (oq_tail_reg == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0
                                                                        : oq_tail_reg + 1'b1;
            end
            if (oq_pop)
            begin
                oq_head_reg <= (oq_head_reg == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0
                                                                        : oq_head_reg + 1'b1;
            end
            case ({oq_push, oq_pop})
                2'b10:   oq_count_reg <= oq_count_reg + 1'b1;
                2'b01:   oq_count_reg <= oq_count_reg - 1'b1;
                default: oq_count_reg <= oq_count_reg;
            endcase
        end
    end

endmodule

// File: hw/rtl/ps2kbd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2kbd_checker
// Port-level checks for the scan code decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ps2kbd_checker
    import ps2kbd_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data
);

    // A stalled result beat stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped while stalled");

    // A stalled result beat keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("out_data changed while stalled");

    // A result is a pop answer, a stored key or a dropped key, at most one of them.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({out_data.event_valid, out_data.queued, out_data.dropped}))
        else $error("more than one result flag set");

    // Every accepted input beat has its result offered once it has passed the read stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##2 out_valid)
        else $error("no result offered for an accepted beat");

    // Without a popped event the key fields read as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.event_valid
            |-> (out_data.key_id == '0) && !out_data.key_pressed)
        else $error("key fields set without an event");

endmodule

bind ps2_set2_scancode_decoder_fifo ps2kbd_checker u_ps2kbd_checker (.*);
